FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the token folder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bftf_pkg.sv
package bftf_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int LABEL_WIDTH_DEF = 16;

    localparam logic [7:0] CH_RIGHT = 8'h3E;  // >
    localparam logic [7:0] CH_LEFT  = 8'h3C;  // <
    localparam logic [7:0] CH_INC   = 8'h2B;  // +
    localparam logic [7:0] CH_DEC   = 8'h2D;  // -
    localparam logic [7:0] CH_OUT   = 8'h2E;  // .
    localparam logic [7:0] CH_IN    = 8'h2C;  // ,
    localparam logic [7:0] CH_OPEN  = 8'h5B;  // [
    localparam logic [7:0] CH_CLOSE = 8'h5D;  // ]

    typedef enum logic [2:0] {
        OP_RIGHT = 3'd0,
        OP_LEFT  = 3'd1,
        OP_INC   = 3'd2,
        OP_DEC   = 3'd3,
        OP_OUT   = 3'd4,
        OP_IN    = 3'd5,
        OP_OPEN  = 3'd6,
        OP_CLOSE = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNMATCHED = 2'd1,
        ERR_TOO_DEEP  = 2'd2,
        ERR_NO_IDS    = 2'd3
    } err_t;

    // Token slots of one item: slot a is a released run, slot b the item's
    // own token or the flushed run.
    typedef struct packed {
        logic a_valid;
        op_t  a_op;
        logic b_valid;
        op_t  b_op;
        err_t b_err;
        logic b_pop;
    } tok_ctrl_t;

endpackage

FILE: rtl/core/bftf_stack_mem.sv
module bftf_stack_mem #(
    parameter int DEPTH = bftf_pkg::STACK_DEPTH_DEF,
    parameter int WIDTH = bftf_pkg::LABEL_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/bftf_decode.sv
`include "assert_macros.svh"

module bftf_decode #(
    parameter int STACK_DEPTH = bftf_pkg::STACK_DEPTH_DEF,
    parameter int COUNT_WIDTH = bftf_pkg::COUNT_WIDTH_DEF,
    parameter int LABEL_WIDTH = bftf_pkg::LABEL_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  logic [7:0]                     symbol,
    input  logic                           end_of_program,
    output bftf_pkg::tok_ctrl_t            tok,
    output logic [COUNT_WIDTH-1:0]         a_count,
    output logic [COUNT_WIDTH-1:0]         b_count,
    output logic [LABEL_WIDTH-1:0]         b_label,
    output logic                           mem_wr_en,
    output logic [$clog2(STACK_DEPTH)-1:0] mem_wr_addr,
    output logic [LABEL_WIDTH-1:0]         mem_wr_data,
    output logic                           mem_rd_en,
    output logic [$clog2(STACK_DEPTH)-1:0] mem_rd_addr
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int LVW = $clog2(STACK_DEPTH + 1);

    logic                   held_valid_reg, held_valid_next;
    logic [1:0]             held_op_reg, held_op_next;
    logic [COUNT_WIDTH-1:0] held_count_reg, held_count_next;
    logic [LABEL_WIDTH-1:0] next_label_reg, next_label_next;
    logic [LVW-1:0]         level_reg, level_next;

    logic           is_run;
    logic [1:0]     run_op;
    logic           extend;
    logic [LVW-1:0] level_m1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_op_reg    <= 2'd0;
            held_count_reg <= '0;
            next_label_reg <= '0;
            level_reg      <= '0;
        end else begin
            held_valid_reg <= held_valid_next;
            held_op_reg    <= held_op_next;
            held_count_reg <= held_count_next;
            next_label_reg <= next_label_next;
            level_reg      <= level_next;
        end
    end

    always_comb begin
        is_run = 1'b1;
        run_op = 2'd0;
        unique case (symbol)
            bftf_pkg::CH_RIGHT: run_op = 2'd0;
            bftf_pkg::CH_LEFT:  run_op = 2'd1;
            bftf_pkg::CH_INC:   run_op = 2'd2;
            bftf_pkg::CH_DEC:   run_op = 2'd3;
            default:            is_run = 1'b0;
        endcase
    end

    assign extend   = held_valid_reg && (held_op_reg == run_op) &&
                      (held_count_reg != {COUNT_WIDTH{1'b1}});
    assign level_m1 = level_reg - 1'b1;

    always_comb begin
        held_valid_next = held_valid_reg;
        held_op_next    = held_op_reg;
        held_count_next = held_count_reg;
        next_label_next = next_label_reg;
        level_next      = level_reg;

        tok.a_valid = 1'b0;
        tok.a_op    = bftf_pkg::op_t'({1'b0, held_op_reg});
        tok.b_valid = 1'b0;
        tok.b_op    = bftf_pkg::OP_OUT;
        tok.b_err   = bftf_pkg::ERR_NONE;
        tok.b_pop   = 1'b0;
        a_count     = held_count_reg;
        b_count     = COUNT_WIDTH'(1);
        b_label     = '0;

        mem_wr_en   = 1'b0;
        mem_wr_addr = level_reg[AW-1:0];
        mem_wr_data = next_label_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = level_m1[AW-1:0];

        if (is_run) begin
            if (extend) begin
                held_count_next = held_count_reg + 1'b1;
            end else begin
                // Release the held run and start a fresh one.
                tok.a_valid     = held_valid_reg;
                held_valid_next = 1'b1;
                held_op_next    = run_op;
                held_count_next = COUNT_WIDTH'(1);
            end
            if (end_of_program) begin
                tok.b_valid     = 1'b1;
                tok.b_op        = bftf_pkg::op_t'({1'b0, run_op});
                b_count         = held_count_next;
                held_valid_next = 1'b0;
                held_op_next    = 2'd0;
                held_count_next = '0;
            end
        end else begin
            tok.a_valid     = held_valid_reg;
            held_valid_next = 1'b0;
            held_op_next    = 2'd0;
            held_count_next = '0;
            priority case (symbol)
                bftf_pkg::CH_OUT: begin
                    tok.b_valid = 1'b1;
                    tok.b_op    = bftf_pkg::OP_OUT;
                end
                bftf_pkg::CH_IN: begin
                    tok.b_valid = 1'b1;
                    tok.b_op    = bftf_pkg::OP_IN;
                end
                bftf_pkg::CH_OPEN: begin
                    tok.b_valid = 1'b1;
                    tok.b_op    = bftf_pkg::OP_OPEN;
                    if (level_reg >= LVW'(STACK_DEPTH)) begin
                        tok.b_err = bftf_pkg::ERR_TOO_DEEP;
                    end else if (next_label_reg == {LABEL_WIDTH{1'b1}}) begin
                        tok.b_err = bftf_pkg::ERR_NO_IDS;
                    end else begin
                        b_label         = next_label_reg;
                        mem_wr_en       = accept;
                        level_next      = level_reg + 1'b1;
                        next_label_next = next_label_reg + 1'b1;
                    end
                end
                bftf_pkg::CH_CLOSE: begin
                    tok.b_valid = 1'b1;
                    tok.b_op    = bftf_pkg::OP_CLOSE;
                    if (level_reg == '0) begin
                        tok.b_err = bftf_pkg::ERR_UNMATCHED;
                    end else begin
                        // Label arrives from the stack memory next cycle.
                        tok.b_pop  = 1'b1;
                        mem_rd_en  = accept;
                        level_next = level_m1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (!accept) begin
            held_valid_next = held_valid_reg;
            held_op_next    = held_op_reg;
            held_count_next = held_count_reg;
            next_label_next = next_label_reg;
            level_next      = level_reg;
        end
    end

    `ASSERT_ALWAYS(a_level_bound, aclk, aresetn, level_reg <= LVW'(STACK_DEPTH), "stack level past depth")
    `ASSERT_ALWAYS(a_no_rw_overlap, aclk, aresetn, !(mem_wr_en && mem_rd_en), "push and pop together")

endmodule

FILE: rtl/core/bftf_out_stage.sv
`include "assert_macros.svh"

module bftf_out_stage #(
    parameter int COUNT_WIDTH = bftf_pkg::COUNT_WIDTH_DEF,
    parameter int LABEL_WIDTH = bftf_pkg::LABEL_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    output logic                   in_ready,
    input  bftf_pkg::tok_ctrl_t    tok,
    input  logic [COUNT_WIDTH-1:0] a_count,
    input  logic [COUNT_WIDTH-1:0] b_count,
    input  logic [LABEL_WIDTH-1:0] b_label,
    input  logic [LABEL_WIDTH-1:0] pop_label,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             out_op,
    output logic [COUNT_WIDTH-1:0] out_count,
    output logic [LABEL_WIDTH-1:0] out_label,
    output logic [1:0]             out_err,
    output logic                   out_last
);

    bftf_pkg::tok_ctrl_t    pend_reg;
    logic [COUNT_WIDTH-1:0] a_count_reg, b_count_reg;
    logic [LABEL_WIDTH-1:0] b_label_reg;

    logic                   m_valid_reg;
    logic [2:0]             m_op_reg;
    logic [COUNT_WIDTH-1:0] m_count_reg;
    logic [LABEL_WIDTH-1:0] m_label_reg;
    logic [1:0]             m_err_reg;
    logic                   m_last_reg;

    logic out_free, pend_any, emit;

    assign out_free = !m_valid_reg || out_ready;
    assign pend_any = pend_reg.a_valid || pend_reg.b_valid;
    assign emit     = pend_any && out_free;
    // Take the next item when none is pending or the last pending token leaves this cycle.
    assign in_ready = !pend_any || (emit && !(pend_reg.a_valid && pend_reg.b_valid));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg.a_valid <= 1'b0;
            pend_reg.b_valid <= 1'b0;
            pend_reg.b_pop   <= 1'b0;
        end else if (accept) begin
            pend_reg <= tok;
        end else if (emit) begin
            if (pend_reg.a_valid) begin
                pend_reg.a_valid <= 1'b0;
            end else begin
                pend_reg.b_valid <= 1'b0;
                pend_reg.b_pop   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_count_reg <= a_count;
            b_count_reg <= b_count;
            b_label_reg <= b_label;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (out_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            if (pend_reg.a_valid) begin
                m_op_reg    <= pend_reg.a_op;
                m_count_reg <= a_count_reg;
                m_label_reg <= '0;
                m_err_reg   <= bftf_pkg::ERR_NONE;
                m_last_reg  <= !pend_reg.b_valid;
            end else begin
                m_op_reg    <= pend_reg.b_op;
                m_count_reg <= b_count_reg;
                m_label_reg <= pend_reg.b_pop ? pop_label : b_label_reg;
                m_err_reg   <= pend_reg.b_err;
                m_last_reg  <= 1'b1;
            end
        end
    end

    assign out_valid = m_valid_reg;
    assign out_op    = m_op_reg;
    assign out_count = m_count_reg;
    assign out_label = m_label_reg;
    assign out_err   = m_err_reg;
    assign out_last  = m_last_reg;

    `ASSERT_IMPLIES(a_ready_one_slot, aclk, aresetn, in_ready, !(pend_reg.a_valid && pend_reg.b_valid), "ready with two tokens pending")
    `ASSERT_IMPLIES(a_pop_in_b, aclk, aresetn, pend_reg.b_pop, pend_reg.b_valid, "pop flag without a token")

endmodule

FILE: rtl/core/brainfuck_token_folder_unit.sv
// Run-length folding tokenizer for the eight-command tape language. Feed one
// program character per item on s_tdata; s_tlast marks the last character and
// flushes any held run. Each result item on m_* is one token: op, repeat
// count, loop label and error code, with m_tlast high on the final token that
// an item causes. Runs of > < + - fold into a single token and split at the
// all-ones count; [ pushes a fresh loop label on a stack memory of
// STACK_DEPTH entries and ] pops and reports it. Unmatched ], overflowing [
// and exhausted labels produce error tokens. Timing: the block moves one
// result item per cycle through its output register while m_tready is high,
// and takes a new item once its one-item token buffer is empty or sends its
// last token; an item that releases a run plus its own token holds the input
// until both have left. The stack memory registers a popped label as the item
// is taken, ready in the cycle after, while its token waits in the buffer.
// No clearing pass; the block takes items from the first cycle out of reset.
module brainfuck_token_folder_unit #(
    parameter int STACK_DEPTH = bftf_pkg::STACK_DEPTH_DEF,
    parameter int COUNT_WIDTH = bftf_pkg::COUNT_WIDTH_DEF,
    parameter int LABEL_WIDTH = bftf_pkg::LABEL_WIDTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Input item channel.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tlast,   // end_of_program
    // Result item channel.
    output logic       m_tvalid,
    input  logic       m_tready,
    // op [2:0], repeat_count, loop_label, error, zero fill to whole bytes
    output logic [((COUNT_WIDTH + LABEL_WIDTH + 5 + 7) / 8) * 8 - 1:0] m_tdata,
    output logic       m_tlast    // last
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int TDW = ((COUNT_WIDTH + LABEL_WIDTH + 5 + 7) / 8) * 8;

    logic                accept;
    bftf_pkg::tok_ctrl_t tok;
    logic [COUNT_WIDTH-1:0] a_count, b_count;
    logic [LABEL_WIDTH-1:0] b_label;

    logic                   mem_wr_en, mem_rd_en;
    logic [AW-1:0]          mem_wr_addr, mem_rd_addr;
    logic [LABEL_WIDTH-1:0] mem_wr_data, mem_rd_data;

    logic [2:0]             out_op;
    logic [COUNT_WIDTH-1:0] out_count;
    logic [LABEL_WIDTH-1:0] out_label;
    logic [1:0]             out_err;

    // Take an item when the token buffer can hold its tokens.
    assign accept = s_tvalid && s_tready;

    // Fold runs, track labels and drive the stack memory on each item.
    bftf_decode #(
        .STACK_DEPTH(STACK_DEPTH),
        .COUNT_WIDTH(COUNT_WIDTH),
        .LABEL_WIDTH(LABEL_WIDTH)
    ) u_decode (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .symbol        (s_tdata),
        .end_of_program(s_tlast),
        .tok           (tok),
        .a_count       (a_count),
        .b_count       (b_count),
        .b_label       (b_label),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr   (mem_rd_addr)
    );

    // Loop label stack; a push and a pop never share a cycle, so a pop
    // always sees the latest push.
    bftf_stack_mem #(
        .DEPTH(STACK_DEPTH),
        .WIDTH(LABEL_WIDTH)
    ) u_stack_mem (
        .aclk   (aclk),
        .wr_en  (mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data),
        .rd_en  (mem_rd_en),
        .rd_addr(mem_rd_addr),
        .rd_data(mem_rd_data)
    );

    // Buffer the item's tokens and drain them through the output register.
    bftf_out_stage #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .LABEL_WIDTH(LABEL_WIDTH)
    ) u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .in_ready (s_tready),
        .tok      (tok),
        .a_count  (a_count),
        .b_count  (b_count),
        .b_label  (b_label),
        .pop_label(mem_rd_data),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_op   (out_op),
        .out_count(out_count),
        .out_label(out_label),
        .out_err  (out_err),
        .out_last (m_tlast)
    );

    // Pack the token fields from the lowest bit up, zero filled.
    assign m_tdata = TDW'({out_err, out_label, out_count, out_op});

endmodule

FILE: sim/brainfuck_token_folder_unit_tb.sv
`timescale 1ns / 100ps

module brainfuck_token_folder_unit_tb;

    // Block geometry, taken from the package defaults.
    localparam int DEPTH     = bftf_pkg::STACK_DEPTH_DEF;
    localparam int CW        = bftf_pkg::COUNT_WIDTH_DEF;
    localparam int LW        = bftf_pkg::LABEL_WIDTH_DEF;
    localparam int AW        = $clog2(DEPTH);
    localparam int TDATA_W   = ((CW + LW + 5 + 7) / 8) * 8;
    localparam int FILL_LSB  = 5 + CW + LW;
    localparam int LABEL_TOP = (1 << LW) - 1;   // the never-issued all-ones id
    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};
    localparam logic [LW-1:0] LABEL_MAX = {LW{1'b1}};

    localparam int RANDOM_ITEMS = 1650;
    localparam int TIMEOUT_NS   = 100_000_000;

    // One token as it leaves the block on the result channel.
    typedef struct packed {
        bftf_pkg::op_t  op;
        logic [CW-1:0]  count;
        logic [LW-1:0]  label;
        bftf_pkg::err_t err;
        logic           last;
    } token_t;

    logic               aclk;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = 8'h00;   // [7:0] symbol
    logic               s_tlast  = 1'b0;    // end_of_program
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // op [2:0], repeat_count, loop_label, error, zero fill to whole bytes
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;            // last

    brainfuck_token_folder_unit #(
        .STACK_DEPTH (DEPTH),
        .COUNT_WIDTH (CW),
        .LABEL_WIDTH (LW)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop in case the block wedges or drops tokens.
    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Folding predictor: its own copy of the tokenizer state.
    // ------------------------------------------------------------------
    logic          held_valid;
    bftf_pkg::op_t held_op;
    logic [CW-1:0] held_count;
    logic [LW-1:0] next_label;
    logic [LW-1:0] label_stack [DEPTH];
    int            stack_level;

    token_t pending_tokens [$];   // tokens the block still owes, oldest first

    int mismatch_count = 0;
    int tokens_checked = 0;
    int items_sent     = 0;
    int command_items  = 0;

    // Sender and receiver shaping.
    bit tx_gap_en   = 1'b1;
    bit rx_stall_en = 1'b1;
    int burst_left  = 0;
    int hold_request = 0;
    int hold_left    = 0;
    int pattern_left = 0;
    int pattern_pct  = 100;

    function automatic void push_token(bftf_pkg::op_t op, logic [CW-1:0] cnt,
                                       logic [LW-1:0] lbl, bftf_pkg::err_t err);
        token_t t;
        t.op    = op;
        t.count = cnt;
        t.label = lbl;
        t.err   = err;
        t.last  = 1'b0;
        pending_tokens.push_back(t);
    endfunction

    // Emit the held run, if any, and clear it.
    function automatic void release_run();
        if (held_valid) begin
            push_token(held_op, held_count, '0, bftf_pkg::ERR_NONE);
            held_valid = 1'b0;
            held_op    = bftf_pkg::OP_RIGHT;
            held_count = '0;
        end
    endfunction

    function automatic void fold_symbol(logic [7:0] sym, logic fin);
        int            made;
        bftf_pkg::op_t run_op;
        logic          is_run;
        token_t        tail;
        made   = pending_tokens.size();
        is_run = 1'b1;
        run_op = bftf_pkg::OP_RIGHT;
        case (sym)
            bftf_pkg::CH_RIGHT: run_op = bftf_pkg::OP_RIGHT;
            bftf_pkg::CH_LEFT:  run_op = bftf_pkg::OP_LEFT;
            bftf_pkg::CH_INC:   run_op = bftf_pkg::OP_INC;
            bftf_pkg::CH_DEC:   run_op = bftf_pkg::OP_DEC;
            default:            is_run = 1'b0;
        endcase
        if (is_run) begin
            // Extend the run unless it changes op or sits at the largest count.
            if (held_valid && held_op == run_op && held_count != COUNT_MAX) begin
                held_count = held_count + 1'b1;
            end else begin
                release_run();
                held_valid = 1'b1;
                held_op    = run_op;
                held_count = CW'(1);
            end
            if (fin) release_run();
        end else begin
            release_run();
            case (sym)
                bftf_pkg::CH_OUT:
                    push_token(bftf_pkg::OP_OUT, CW'(1), '0, bftf_pkg::ERR_NONE);
                bftf_pkg::CH_IN:
                    push_token(bftf_pkg::OP_IN, CW'(1), '0, bftf_pkg::ERR_NONE);
                bftf_pkg::CH_OPEN: begin
                    // Depth is tested before id exhaustion.
                    if (stack_level >= DEPTH) begin
                        push_token(bftf_pkg::OP_OPEN, CW'(1), '0, bftf_pkg::ERR_TOO_DEEP);
                    end else if (next_label == LABEL_MAX) begin
                        push_token(bftf_pkg::OP_OPEN, CW'(1), '0, bftf_pkg::ERR_NO_IDS);
                    end else begin
                        label_stack[stack_level[AW-1:0]] = next_label;
                        stack_level++;
                        push_token(bftf_pkg::OP_OPEN, CW'(1), next_label,
                                   bftf_pkg::ERR_NONE);
                        next_label = next_label + 1'b1;
                    end
                end
                bftf_pkg::CH_CLOSE: begin
                    if (stack_level == 0) begin
                        push_token(bftf_pkg::OP_CLOSE, CW'(1), '0,
                                   bftf_pkg::ERR_UNMATCHED);
                    end else begin
                        stack_level--;
                        push_token(bftf_pkg::OP_CLOSE, CW'(1),
                                   label_stack[stack_level[AW-1:0]], bftf_pkg::ERR_NONE);
                    end
                end
                default: ;
            endcase
        end
        // Flag the final token of this item.
        if (pending_tokens.size() > made) begin
            tail      = pending_tokens.pop_back();
            tail.last = 1'b1;
            pending_tokens.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking.
    // ------------------------------------------------------------------
    function automatic void log_mismatch(string what, token_t want, token_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected op=%s count=%0d label=%0d err=%s last=%b, got op=%s count=%0d label=%0d err=%s last=%b data=%h",
                     $realtime, what, want.op.name(), want.count, want.label, want.err.name(),
                     want.last, got.op.name(), got.count, got.label, got.err.name(),
                     got.last, m_tdata);
    endfunction

    // Compare every accepted token against the oldest one owed.
    always @(posedge aclk) begin : token_check
        token_t got;
        token_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.op    = bftf_pkg::op_t'(m_tdata[2:0]);
            got.count = m_tdata[3 +: CW];
            got.label = m_tdata[3 + CW +: LW];
            got.err   = bftf_pkg::err_t'(m_tdata[3 + CW + LW +: 2]);
            got.last  = m_tlast;
            tokens_checked++;
            if (pending_tokens.size() == 0) begin
                log_mismatch("token with none pending", got, got);
            end else begin
                want = pending_tokens.pop_front();
                if (got !== want || (m_tdata >> FILL_LSB) != '0)
                    log_mismatch("token mismatch", want, got);
            end
        end
    end

    // Receiver: an explicit long hold wins; with stalls off it always accepts,
    // otherwise at a random rate redrawn per stretch (100% means no stalls).
    always @(posedge aclk) begin : rx_pattern
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_request > 0) begin
            hold_left    = hold_request - 1;
            hold_request = 0;
            m_tready <= 1'b0;
        end else if (!rx_stall_en) begin
            m_tready <= 1'b1;
        end else begin
            if (pattern_left == 0) begin
                case ($urandom_range(3))
                    0:       pattern_pct = 100;
                    1:       pattern_pct = 80;
                    2:       pattern_pct = 50;
                    default: pattern_pct = 20;
                endcase
                pattern_left = $urandom_range(16, 96);
            end
            pattern_left--;
            m_tready <= ($urandom_range(99) < pattern_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Offer one item and hold it until the block takes it.
    task automatic send_symbol(input logic [7:0] sym, input logic fin);
        int gap;
        if (tx_gap_en) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        fold_symbol(sym, fin);
        items_sent++;
        if (sym inside {bftf_pkg::CH_RIGHT, bftf_pkg::CH_LEFT, bftf_pkg::CH_INC,
                        bftf_pkg::CH_DEC, bftf_pkg::CH_OUT, bftf_pkg::CH_IN,
                        bftf_pkg::CH_OPEN, bftf_pkg::CH_CLOSE})
            command_items++;
    endtask

    // Drop valid and wait on the clock so the next item starts clean.
    task automatic idle_bus();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Pause the sender until every owed token has arrived.
    task automatic wait_tokens_drained();
        idle_bus();
        while (pending_tokens.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [7:0] run_char(int sel);
        case (sel % 4)
            0:       return bftf_pkg::CH_RIGHT;
            1:       return bftf_pkg::CH_LEFT;
            2:       return bftf_pkg::CH_INC;
            default: return bftf_pkg::CH_DEC;
        endcase
    endfunction

    // Anything at all, weighted toward whitespace.
    function automatic logic [7:0] noise_char();
        case ($urandom_range(3))
            0:       return 8'h20;
            1:       return 8'h0A;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Every op, run release and flush, unmatched close.
    task automatic test_directed_tokens();
        send_symbol(bftf_pkg::CH_RIGHT, 1'b1);            // single run flushed by end flag
        repeat (3) send_symbol(bftf_pkg::CH_LEFT, 1'b0);
        send_symbol(bftf_pkg::CH_OUT, 1'b0);              // release plus own token
        send_symbol(bftf_pkg::CH_INC, 1'b0);
        send_symbol(bftf_pkg::CH_INC, 1'b0);
        send_symbol(bftf_pkg::CH_DEC, 1'b0);              // op change releases the run
        send_symbol(bftf_pkg::CH_DEC, 1'b1);
        send_symbol(bftf_pkg::CH_IN, 1'b0);
        send_symbol(bftf_pkg::CH_OPEN, 1'b0);
        send_symbol(bftf_pkg::CH_OPEN, 1'b0);
        send_symbol(bftf_pkg::CH_CLOSE, 1'b0);
        send_symbol(bftf_pkg::CH_CLOSE, 1'b0);
        send_symbol(bftf_pkg::CH_CLOSE, 1'b0);            // unmatched close
        send_symbol(bftf_pkg::CH_INC, 1'b0);
        send_symbol(8'h20, 1'b0);                         // whitespace only ends the run
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b1);                         // noise with end flag: nothing
        send_symbol(bftf_pkg::CH_RIGHT, 1'b0);
        send_symbol(bftf_pkg::CH_LEFT, 1'b1);             // release, then flush new run
        send_symbol(bftf_pkg::CH_OUT, 1'b1);
        wait_tokens_drained();
    endtask

    // Fill the label stack, overflow it, then unwind past empty.
    task automatic test_nesting_limits();
        repeat (DEPTH) send_symbol(bftf_pkg::CH_OPEN, 1'b0);
        send_symbol(bftf_pkg::CH_OPEN, 1'b0);             // nesting too deep
        repeat (DEPTH) send_symbol(bftf_pkg::CH_CLOSE, 1'b0);
        send_symbol(bftf_pkg::CH_CLOSE, 1'b1);            // unmatched close
        wait_tokens_drained();
    endtask

    // Hold the receiver off while the sender keeps offering items, half of them two-token items.
    task automatic test_backpressure_fill();
        tx_gap_en    = 1'b0;
        hold_request = 400;
        for (int i = 0; i < 60; i++) begin
            send_symbol(run_char(i), 1'b0);
            send_symbol((i % 2) ? bftf_pkg::CH_OUT : bftf_pkg::CH_IN, 1'b0);
        end
        send_symbol(bftf_pkg::CH_OPEN, 1'b0);
        send_symbol(bftf_pkg::CH_CLOSE, 1'b1);
        tx_gap_en = 1'b1;
        wait_tokens_drained();
    endtask

    // Mostly well-formed programs with random content; some broken ones.
    task automatic random_program();
        int         len;
        int         depth;
        int         kind;
        int         n;
        bit         broken;
        logic [7:0] ch;
        len    = $urandom_range(4, 40);
        depth  = 0;
        broken = ($urandom_range(7) == 0);
        for (int i = 0; i < len; i++) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                ch = run_char($urandom_range(3));
                n  = (kind < 3) ? $urandom_range(10, 40) : $urandom_range(1, 6);
                repeat (n) send_symbol(ch, broken && $urandom_range(15) == 0);
            end else if (kind < 55) begin
                send_symbol($urandom_range(1) ? bftf_pkg::CH_OUT : bftf_pkg::CH_IN,
                            broken && $urandom_range(15) == 0);
            end else if (kind < 70) begin
                send_symbol(bftf_pkg::CH_OPEN, 1'b0);
                depth++;
            end else if (kind < 85) begin
                if (depth > 0 || broken) begin
                    send_symbol(bftf_pkg::CH_CLOSE, 1'b0);
                    if (depth > 0) depth--;
                end
            end else begin
                send_symbol(noise_char(), $urandom_range(7) == 0);
            end
        end
        if (!broken) begin
            repeat (depth) send_symbol(bftf_pkg::CH_CLOSE, 1'b0);
        end
        // Close out the program with the end flag on a random kind of item.
        case ($urandom_range(4))
            0, 1:    send_symbol(run_char($urandom_range(3)), 1'b1);
            2:       send_symbol(bftf_pkg::CH_OUT, 1'b1);
            3:       send_symbol(bftf_pkg::CH_CLOSE, 1'b1);
            default: send_symbol(noise_char(), 1'b1);
        endcase
    endtask

    task automatic test_random_programs();
        int start;
        start = command_items;
        while (command_items - start < RANDOM_ITEMS) begin
            random_program();
            if ($urandom_range(7) == 0) wait_tokens_drained();
        end
        wait_tokens_drained();
    endtask

    // A run that reaches the all-ones count splits and restarts at one.
    task automatic test_count_split();
        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b0;
        send_symbol(bftf_pkg::CH_RIGHT, 1'b0);
        repeat (int'(COUNT_MAX)) send_symbol(bftf_pkg::CH_INC, 1'b0);
        send_symbol(bftf_pkg::CH_INC, 1'b1);              // split, then flush a run of one
        wait_tokens_drained();
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    // Burn loop ids down to the all-ones id; deep nesting wins over no ids.
    task automatic test_label_exhaustion();
        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b0;
        while (stack_level > 0) send_symbol(bftf_pkg::CH_CLOSE, 1'b0);
        while (int'(next_label) < LABEL_TOP - DEPTH) begin
            send_symbol(bftf_pkg::CH_OPEN, 1'b0);
            send_symbol(bftf_pkg::CH_CLOSE, 1'b0);
        end
        repeat (DEPTH) send_symbol(bftf_pkg::CH_OPEN, 1'b0);
        send_symbol(bftf_pkg::CH_OPEN, 1'b0);             // full stack and no ids left
        send_symbol(bftf_pkg::CH_CLOSE, 1'b0);
        rx_stall_en = 1'b1;
        tx_gap_en   = 1'b1;
        send_symbol(bftf_pkg::CH_OPEN, 1'b0);             // ids exhausted
        send_symbol(bftf_pkg::CH_OPEN, 1'b1);
        repeat (DEPTH) send_symbol(bftf_pkg::CH_CLOSE, 1'b0);
        send_symbol(bftf_pkg::CH_CLOSE, 1'b1);
        wait_tokens_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence.
    // ------------------------------------------------------------------
    initial begin
        held_valid  = 1'b0;
        held_op     = bftf_pkg::OP_RIGHT;
        held_count  = '0;
        next_label  = '0;
        stack_level = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_tokens();
        test_nesting_limits();
        test_backpressure_fill();
        test_random_programs();
        test_count_split();
        test_label_exhaustion();

        // Let stragglers land, bounded, then let the bus settle.
        idle_bus();
        for (int w = 0; w < 200000 && pending_tokens.size() != 0; w++) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (pending_tokens.size() != 0) begin
            mismatch_count++;
            $display("%0d tokens never arrived", pending_tokens.size());
        end

        $display("Covered: run folding and count split, loops, nesting and id limits, noise, stalls.");
        $display("%0d items sent, %0d tokens checked, %0d mismatches.",
                 items_sent, tokens_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/bftf_pkg.sv
rtl/core/bftf_stack_mem.sv
rtl/core/bftf_decode.sv
rtl/core/bftf_out_stage.sv
rtl/core/brainfuck_token_folder_unit.sv
sim/brainfuck_token_folder_unit_tb.sv
